/* hw/rtl/dlpe_pkg.sv */
// ----------------------------------------------------------------------------
// dlpe_pkg
// Shared types and constants of the display link protocol engine.
// ----------------------------------------------------------------------------
`default_nettype none

package dlpe_pkg;

    // Command codes
    localparam logic [2:0] CMD_REG_READ  = 3'd0;
    localparam logic [2:0] CMD_REG_WRITE = 3'd1;
    localparam logic [2:0] CMD_VAR_READ  = 3'd2;
    localparam logic [2:0] CMD_VAR_WRITE = 3'd3;
    localparam logic [2:0] CMD_PAYLOAD   = 3'd4;
    localparam logic [2:0] CMD_RX_BYTE   = 3'd5;

    // Result kinds
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_UPLOAD = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_REJECT   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_HEADER_HIGH = 2'd0;
    localparam logic [1:0] CFG_HEADER_LOW  = 2'd1;

    localparam logic [7:0] HEADER_HIGH_RST = 8'h5A;
    localparam logic [7:0] HEADER_LOW_RST  = 8'hA5;
    localparam logic [7:0] ACK_HIGH        = 8'h4F;
    localparam logic [7:0] ACK_LOW         = 8'h4B;
    localparam logic [7:0] VAR_READ_MAX    = 8'h7D;

    localparam int MAX_BEATS       = 7;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
        logic        last;
        logic [1:0]  status;
    } t_beat;

    typedef struct packed {
        t_beat [MAX_BEATS-1:0] beats;
        logic  [2:0]           num;
    } t_job;

    // Frame opcode for a start command
    function automatic logic [7:0] opcode_of(input logic [1:0] op);
        logic [7:0] r;
        case (op)
            2'd0:    r = 8'h81;
            2'd1:    r = 8'h80;
            2'd2:    r = 8'h83;
            default: r = 8'h82;
        endcase
        return r;
    endfunction

    // Largest count a start command may carry
    function automatic logic [7:0] count_max(input logic [1:0] op);
        logic [7:0] r;
        case (op)
            2'd0:    r = 8'd251;
            2'd1:    r = 8'd252;
            2'd2:    r = VAR_READ_MAX;
            default: r = 8'd126;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/dlpe_front.sv */
// ----------------------------------------------------------------------------
// dlpe_front
// Accepts commands and received bytes, tracks the transaction and upload
// deframer state, and turns each item into a job of result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module dlpe_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [7:0]      i_cfg_data,
    input  wire logic            i_take,
    input  wire logic [2:0]      i_command,
    input  wire logic [15:0]     i_address,
    input  wire logic [7:0]      i_count,
    input  wire logic [15:0]     i_payload,
    input  wire logic [7:0]      i_rx_byte,
    output dlpe_pkg::t_job       o_job,
    output logic                 o_push
);

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_PAYLOAD = 4'b0010,
        PH_ACK     = 4'b0100,
        PH_READ    = 4'b1000
    } t_phase;

    typedef enum logic [3:0] {
        UP_IDLE = 4'b0001,
        UP_HIGH = 4'b0010,
        UP_LOW  = 4'b0100,
        UP_DATA = 4'b1000
    } t_up;

    logic [7:0]  r_hdr_hi, r_hdr_lo;
    t_phase      r_phase, n_phase;
    logic [1:0]  r_op, n_op;
    logic [15:0] r_addr, n_addr;
    logic [7:0]  r_cnt, n_cnt;
    logic [7:0]  r_left, n_left;
    logic [8:0]  r_pos, n_pos;
    logic        r_mism, n_mism;
    logic [7:0]  r_held, n_held;
    t_up         r_up, n_up;
    logic [7:0]  r_up_len, n_up_len;
    logic [8:0]  r_up_pos, n_up_pos;

    dlpe_pkg::t_job job;

    // Hold the header registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_hi <= dlpe_pkg::HEADER_HIGH_RST;
            r_hdr_lo <= dlpe_pkg::HEADER_LOW_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == dlpe_pkg::CFG_HEADER_HIGH) r_hdr_hi <= i_cfg_data;
            if (i_cfg_index == dlpe_pkg::CFG_HEADER_LOW)  r_hdr_lo <= i_cfg_data;
        end
    end

    function automatic dlpe_pkg::t_beat mk(input logic [1:0] k, input logic [15:0] v,
                                           input logic l, input logic [1:0] s);
        dlpe_pkg::t_beat b;
        b.kind   = k;
        b.value  = v;
        b.last   = l;
        b.status = s;
        return b;
    endfunction

    // Classify the item and compute next state and result beats
    always_comb begin
        logic [2:0] k;
        logic [7:0] len;
        logic [7:0] exp_b;
        logic [9:0] total;
        logic       fin;
        logic       is_read;
        n_phase  = r_phase;  n_op = r_op;   n_addr = r_addr; n_cnt = r_cnt;
        n_left   = r_left;   n_pos = r_pos; n_mism = r_mism; n_held = r_held;
        n_up     = r_up;     n_up_len = r_up_len; n_up_pos = r_up_pos;
        job      = '0;
        k        = 3'd0;
        len      = 8'd0;
        exp_b    = 8'd0;
        total    = 10'd0;
        fin      = 1'b0;
        is_read  = (i_command == dlpe_pkg::CMD_REG_READ) ||
                   (i_command == dlpe_pkg::CMD_VAR_READ);
        case (i_command)
            dlpe_pkg::CMD_REG_READ, dlpe_pkg::CMD_REG_WRITE,
            dlpe_pkg::CMD_VAR_READ, dlpe_pkg::CMD_VAR_WRITE: begin
                if (r_phase != PH_IDLE || i_count == 8'd0 ||
                    i_count > dlpe_pkg::count_max(i_command[1:0])) begin
                    job.beats[0] = mk(dlpe_pkg::KIND_STATUS, 16'd0, 1'b0, dlpe_pkg::ST_REJECT);
                    job.num      = 3'd1;
                end else begin
                    if (is_read) len = 8'd4;
                    else if (i_command == dlpe_pkg::CMD_REG_WRITE) len = i_count + 8'd3;
                    else len = {i_count[6:0], 1'b0} + 8'd3;
                    job.beats[0] = mk(dlpe_pkg::KIND_TX, {8'd0, r_hdr_hi}, 1'b0, 2'd0);
                    job.beats[1] = mk(dlpe_pkg::KIND_TX, {8'd0, r_hdr_lo}, 1'b0, 2'd0);
                    job.beats[2] = mk(dlpe_pkg::KIND_TX, {8'd0, len}, 1'b0, 2'd0);
                    job.beats[3] = mk(dlpe_pkg::KIND_TX,
                                      {8'd0, dlpe_pkg::opcode_of(i_command[1:0])}, 1'b0, 2'd0);
                    job.beats[4] = mk(dlpe_pkg::KIND_TX, {8'd0, i_address[15:8]}, 1'b0, 2'd0);
                    job.beats[5] = mk(dlpe_pkg::KIND_TX, {8'd0, i_address[7:0]}, 1'b0, 2'd0);
                    job.beats[6] = mk(dlpe_pkg::KIND_TX, {8'd0, i_count}, 1'b0, 2'd0);
                    job.num      = is_read ? 3'd7 : 3'd6;
                    n_op     = i_command[1:0];
                    n_addr   = i_address;
                    n_cnt    = i_count;
                    n_left   = is_read ? 8'd0 : i_count;
                    n_pos    = 9'd0;
                    n_mism   = 1'b0;
                    n_held   = 8'd0;
                    n_up     = UP_IDLE;
                    n_up_len = 8'd0;
                    n_up_pos = 9'd0;
                    n_phase  = is_read ? PH_READ : PH_PAYLOAD;
                end
            end
            dlpe_pkg::CMD_PAYLOAD: begin
                if (r_phase != PH_PAYLOAD) begin
                    job.beats[0] = mk(dlpe_pkg::KIND_STATUS, 16'd0, 1'b0, dlpe_pkg::ST_REJECT);
                    job.num      = 3'd1;
                end else begin
                    if (r_op == dlpe_pkg::CMD_VAR_WRITE[1:0]) begin
                        job.beats[0] = mk(dlpe_pkg::KIND_TX, {8'd0, i_payload[15:8]}, 1'b0, 2'd0);
                        job.beats[1] = mk(dlpe_pkg::KIND_TX, {8'd0, i_payload[7:0]}, 1'b0, 2'd0);
                        job.num      = 3'd2;
                    end else begin
                        job.beats[0] = mk(dlpe_pkg::KIND_TX, {8'd0, i_payload[7:0]}, 1'b0, 2'd0);
                        job.num      = 3'd1;
                    end
                    n_left = r_left - 8'd1;
                    if (r_left == 8'd1) begin
                        n_phase = PH_ACK;
                        n_pos   = 9'd0;
                        n_mism  = 1'b0;
                    end
                end
            end
            dlpe_pkg::CMD_RX_BYTE: begin
                case (r_phase)
                    PH_IDLE: begin
                        // Unsolicited upload frame deframer
                        case (r_up)
                            UP_IDLE: if (i_rx_byte == r_hdr_hi) n_up = UP_HIGH;
                            UP_HIGH: n_up = (i_rx_byte == r_hdr_lo) ? UP_LOW : UP_IDLE;
                            UP_LOW: begin
                                n_up_len = i_rx_byte;
                                n_up_pos = 9'd0;
                                job.beats[0] = mk(dlpe_pkg::KIND_UPLOAD, {8'd0, r_hdr_hi},
                                                  1'b0, 2'd0);
                                job.beats[1] = mk(dlpe_pkg::KIND_UPLOAD, {8'd0, r_hdr_lo},
                                                  1'b0, 2'd0);
                                job.beats[2] = mk(dlpe_pkg::KIND_UPLOAD, {8'd0, i_rx_byte},
                                                  i_rx_byte == 8'd0, 2'd0);
                                job.num      = 3'd3;
                                n_up = (i_rx_byte == 8'd0) ? UP_IDLE : UP_DATA;
                            end
                            default: begin
                                n_up_pos = r_up_pos + 9'd1;
                                if (n_up_pos >= {1'b0, r_up_len}) begin
                                    job.beats[0] = mk(dlpe_pkg::KIND_UPLOAD, {8'd0, i_rx_byte},
                                                      1'b1, 2'd0);
                                    n_up     = UP_IDLE;
                                    n_up_len = 8'd0;
                                    n_up_pos = 9'd0;
                                end else begin
                                    job.beats[0] = mk(dlpe_pkg::KIND_UPLOAD, {8'd0, i_rx_byte},
                                                      1'b0, 2'd0);
                                end
                                job.num = 3'd1;
                            end
                        endcase
                    end
                    PH_ACK: begin
                        case (r_pos[2:0])
                            3'd0:    exp_b = r_hdr_hi;
                            3'd1:    exp_b = r_hdr_lo;
                            3'd2:    exp_b = 8'd3;
                            3'd3:    exp_b = dlpe_pkg::opcode_of(r_op);
                            3'd4:    exp_b = dlpe_pkg::ACK_HIGH;
                            default: exp_b = dlpe_pkg::ACK_LOW;
                        endcase
                        n_mism = r_mism | (i_rx_byte != exp_b);
                        n_pos  = r_pos + 9'd1;
                        if (n_pos >= 9'd6) begin
                            job.beats[0] = mk(dlpe_pkg::KIND_STATUS, 16'd0, 1'b0,
                                              n_mism ? dlpe_pkg::ST_MISMATCH : dlpe_pkg::ST_OK);
                            job.num  = 3'd1;
                            n_phase  = PH_IDLE;
                            n_left   = 8'd0;
                            n_pos    = 9'd0;
                            n_up     = UP_IDLE;
                            n_up_len = 8'd0;
                            n_up_pos = 9'd0;
                        end
                    end
                    PH_READ: begin
                        total = (r_op == dlpe_pkg::CMD_VAR_READ[1:0]) ?
                                10'd7 + {1'b0, r_cnt, 1'b0} : 10'd7 + {2'b0, r_cnt};
                        fin   = ({1'b0, r_pos} + 10'd1) >= total;
                        case (r_pos[2:0])
                            3'd0: exp_b = r_hdr_hi;
                            3'd1: exp_b = r_hdr_lo;
                            3'd2: exp_b = (r_op == dlpe_pkg::CMD_VAR_READ[1:0]) ?
                                          {r_cnt[6:0], 1'b0} + 8'd4 : r_cnt + 8'd4;
                            3'd3: exp_b = dlpe_pkg::opcode_of(r_op);
                            3'd4: exp_b = r_addr[15:8];
                            3'd5: exp_b = r_addr[7:0];
                            default: exp_b = r_cnt;
                        endcase
                        if (r_pos < 9'd7) begin
                            if (i_rx_byte != exp_b) n_mism = 1'b1;
                        end else if (r_op == dlpe_pkg::CMD_VAR_READ[1:0]) begin
                            if (r_pos[0]) begin
                                n_held = i_rx_byte;
                            end else if (!r_mism) begin
                                job.beats[0] = mk(dlpe_pkg::KIND_READ, {r_held, i_rx_byte},
                                                  fin, 2'd0);
                                k = 3'd1;
                            end
                        end else if (!r_mism) begin
                            job.beats[0] = mk(dlpe_pkg::KIND_READ, {8'd0, i_rx_byte}, fin, 2'd0);
                            k = 3'd1;
                        end
                        n_pos = r_pos + 9'd1;
                        if (fin) begin
                            job.beats[k] = mk(dlpe_pkg::KIND_STATUS, 16'd0, 1'b0,
                                              n_mism ? dlpe_pkg::ST_MISMATCH : dlpe_pkg::ST_OK);
                            k        = k + 3'd1;
                            n_phase  = PH_IDLE;
                            n_left   = 8'd0;
                            n_pos    = 9'd0;
                            n_up     = UP_IDLE;
                            n_up_len = 8'd0;
                            n_up_pos = 9'd0;
                        end
                        job.num = k;
                    end
                    default: begin
                        // Drop received bytes during the write payload phase
                    end
                endcase
            end
            default: begin
                job.beats[0] = mk(dlpe_pkg::KIND_STATUS, 16'd0, 1'b0, dlpe_pkg::ST_REJECT);
                job.num      = 3'd1;
            end
        endcase
    end

    assign o_job  = job;
    assign o_push = i_take && (job.num != 3'd0);

    // Advance state on an accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_op     <= 2'd0;
            r_addr   <= 16'd0;
            r_cnt    <= 8'd0;
            r_left   <= 8'd0;
            r_pos    <= 9'd0;
            r_mism   <= 1'b0;
            r_held   <= 8'd0;
            r_up     <= UP_IDLE;
            r_up_len <= 8'd0;
            r_up_pos <= 9'd0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_op     <= n_op;
            r_addr   <= n_addr;
            r_cnt    <= n_cnt;
            r_left   <= n_left;
            r_pos    <= n_pos;
            r_mism   <= n_mism;
            r_held   <= n_held;
            r_up     <= n_up;
            r_up_len <= n_up_len;
            r_up_pos <= n_up_pos;
        end
    end

    a_deframer_idle_in_txn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_up == UP_IDLE))
        else $error("deframer active during a transaction");

    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_left != 8'd0))
        else $error("payload phase with nothing left");

endmodule

`default_nettype wire

/* hw/rtl/dlpe_queue.sv */
// ----------------------------------------------------------------------------
// dlpe_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module dlpe_queue #(
    parameter int DEPTH = dlpe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire dlpe_pkg::t_job i_job,
    input  wire logic           i_pop,
    output dlpe_pkg::t_job      o_job,
    output logic                o_empty,
    output logic                o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dlpe_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;

    assign o_empty = (r_cnt == CW'(0));
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_job   = r_mem[r_rp];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            if (i_pop)  r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + CW'(1);
            else if (!i_push && i_pop) r_cnt <= r_cnt - CW'(1);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");

endmodule

`default_nettype wire

/* hw/rtl/dlpe_back.sv */
// ----------------------------------------------------------------------------
// dlpe_back
// Pops jobs from the queue and sends their result beats one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module dlpe_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire dlpe_pkg::t_job i_job,
    input  wire logic           i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_stall,
    output dlpe_pkg::t_beat     o_beat
);

    dlpe_pkg::t_job r_job;
    logic [2:0]     r_idx;
    logic           r_busy;
    logic           done;

    assign done    = r_busy && !i_stall && (r_idx + 3'd1 == r_job.num);
    assign o_pop   = (!r_busy || done) && !i_empty;
    assign o_valid = r_busy;
    assign o_beat  = r_job.beats[r_idx];

    // Load a new job or step through the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
            r_job  <= '0;
        end else if (o_pop) begin
            r_job  <= i_job;
            r_idx  <= 3'd0;
            r_busy <= 1'b1;
        end else if (done) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (r_busy && !i_stall) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx < r_job.num))
        else $error("beat index past job end");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && i_stall) |=> (r_busy && $stable(r_idx)))
        else $error("beat moved while stalled");

endmodule

`default_nettype wire

/* hw/rtl/display_link_protocol_engine.sv */
// ----------------------------------------------------------------------------
// display_link_protocol_engine
// Host side of a serial display link: frames commands, checks echoes and
// acknowledges, forwards read data and deframes unsolicited uploads.
// ----------------------------------------------------------------------------
// Path: an accepted item's result beats are written into the job queue and
// then loaded into the back part, which presents them on the output in order.
// Throughput: one item per cycle while the queue is not full; the back part
// emits one beat per cycle unless the output stalls; an item has up to 7 results.
// The job queue (default 4 deep) absorbs bursts; input stalls when it is full.
// Reset: synchronous active low; clears all state, headers to 5A/A5.
`default_nettype none

module display_link_protocol_engine #(
    parameter int QUEUE_DEPTH = dlpe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_command,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_count,
    input  wire logic [15:0] i_payload,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic [15:0]      o_value,
    output logic             o_last,
    output logic [1:0]       o_status
);

    dlpe_pkg::t_job  f_job, q_job;
    dlpe_pkg::t_beat beat;
    logic            push, pop, empty, full, take;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = full;
    assign take        = i_in_valid && !full;

    dlpe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_take      (take),
        .i_command   (i_command),
        .i_address   (i_address),
        .i_count     (i_count),
        .i_payload   (i_payload),
        .i_rx_byte   (i_rx_byte),
        .o_job       (f_job),
        .o_push      (push)
    );

    dlpe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_pop   (pop),
        .o_job   (q_job),
        .o_empty (empty),
        .o_full  (full)
    );

    dlpe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (q_job),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_beat  (beat)
    );

    assign o_kind   = beat.kind;
    assign o_value  = beat.value;
    assign o_last   = beat.last;
    assign o_status = beat.status;

    a_status_only_with_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != dlpe_pkg::KIND_STATUS) |-> (o_status == dlpe_pkg::ST_OK))
        else $error("status set on a non-status beat");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the display link protocol engine: drives command,
// payload and received-byte beats, predicts every result beat and checks
// them in order, under several idle, stall and header settings.
// ----------------------------------------------------------------------------
`default_nettype none

class link_scoreboard;
    typedef struct {
        logic [1:0]  kind;
        logic [15:0] value;
        logic        last;
        logic [1:0]  status;
    } beat_t;

    // predicted state of the engine
    logic [7:0]  hdr_hi, hdr_lo;
    logic [2:0]  phase;          // 0 idle, 1 payload, 2 ack, 3 read
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  cnt, left, held;
    int unsigned rxpos;
    bit          mism;
    logic [1:0]  up_ph;
    logic [7:0]  up_len;
    int unsigned up_pos;

    beat_t pending[$];
    int    errors;

    function new();
        errors = 0;
        hdr_hi = dlpe_pkg::HEADER_HIGH_RST;
        hdr_lo = dlpe_pkg::HEADER_LOW_RST;
        op = 2'd0; addr = 16'd0; cnt = 8'd0; held = 8'd0; mism = 1'b0;
        finish_txn();
    endfunction

    function void push(logic [1:0] k, logic [15:0] v, logic l, logic [1:0] s);
        beat_t b;
        b.kind = k; b.value = v; b.last = l; b.status = s;
        pending.push_back(b);
    endfunction

    function void restart_deframer();
        up_ph = 2'd0; up_len = 8'd0; up_pos = 0;
    endfunction

    function void finish_txn();
        phase = 3'd0; left = 8'd0; rxpos = 0;
        restart_deframer();
    endfunction

    function logic [7:0] opcode(logic [1:0] o);
        case (o)
            2'd0: return 8'h81;
            2'd1: return 8'h80;
            2'd2: return 8'h83;
            default: return 8'h82;
        endcase
    endfunction

    function void set_header(logic [1:0] idx, logic [7:0] d);
        if (idx == dlpe_pkg::CFG_HEADER_HIGH) hdr_hi = d;
        else if (idx == dlpe_pkg::CFG_HEADER_LOW) hdr_lo = d;
    endfunction

    // upload deframer, active outside a transaction
    function void deframe(logic [7:0] b);
        case (up_ph)
            2'd0: if (b == hdr_hi) up_ph = 2'd1;
            2'd1: up_ph = (b == hdr_lo) ? 2'd2 : 2'd0;
            2'd2: begin
                up_len = b; up_pos = 0;
                push(dlpe_pkg::KIND_UPLOAD, {8'h0, hdr_hi}, 1'b0, dlpe_pkg::ST_OK);
                push(dlpe_pkg::KIND_UPLOAD, {8'h0, hdr_lo}, 1'b0, dlpe_pkg::ST_OK);
                push(dlpe_pkg::KIND_UPLOAD, {8'h0, b}, b == 8'd0, dlpe_pkg::ST_OK);
                up_ph = (b == 8'd0) ? 2'd0 : 2'd3;
            end
            default: begin
                up_pos = (up_pos + 1) & 9'h1FF;
                if (up_pos >= up_len) begin
                    push(dlpe_pkg::KIND_UPLOAD, {8'h0, b}, 1'b1, dlpe_pkg::ST_OK);
                    restart_deframer();
                end else begin
                    push(dlpe_pkg::KIND_UPLOAD, {8'h0, b}, 1'b0, dlpe_pkg::ST_OK);
                end
            end
        endcase
    endfunction

    function logic [7:0] echo_byte(int unsigned p);
        case (p)
            0: return hdr_hi;
            1: return hdr_lo;
            2: return (op == 2'd2) ? 8'(cnt * 2 + 4) : 8'(cnt + 4);
            3: return opcode(op);
            4: return addr[15:8];
            5: return addr[7:0];
            default: return cnt;
        endcase
    endfunction

    function logic [7:0] ack_byte(int unsigned p);
        case (p)
            0: return hdr_hi;
            1: return hdr_lo;
            2: return 8'h03;
            3: return opcode(op);
            4: return dlpe_pkg::ACK_HIGH;
            default: return dlpe_pkg::ACK_LOW;
        endcase
    endfunction

    function void reject();
        push(dlpe_pkg::KIND_STATUS, 16'd0, 1'b0, dlpe_pkg::ST_REJECT);
    endfunction

    // note one accepted input beat and predict its results
    function void note_input(logic [2:0] c, logic [15:0] a, logic [7:0] n,
                             logic [15:0] pay, logic [7:0] rx);
        int unsigned total, len;
        bit fin, rd;
        if (c <= dlpe_pkg::CMD_VAR_WRITE) begin
            rd = (c == dlpe_pkg::CMD_REG_READ || c == dlpe_pkg::CMD_VAR_READ);
            if (phase != 3'd0 || n == 8'd0 || n > dlpe_pkg::count_max(c[1:0])) begin
                reject();
                return;
            end
            len = rd ? 4 : (c == dlpe_pkg::CMD_REG_WRITE) ? n + 3 : n * 2 + 3;
            push(dlpe_pkg::KIND_TX, {8'h0, hdr_hi}, 1'b0, dlpe_pkg::ST_OK);
            push(dlpe_pkg::KIND_TX, {8'h0, hdr_lo}, 1'b0, dlpe_pkg::ST_OK);
            push(dlpe_pkg::KIND_TX, {8'h0, 8'(len)}, 1'b0, dlpe_pkg::ST_OK);
            push(dlpe_pkg::KIND_TX, {8'h0, opcode(c[1:0])}, 1'b0, dlpe_pkg::ST_OK);
            push(dlpe_pkg::KIND_TX, {8'h0, a[15:8]}, 1'b0, dlpe_pkg::ST_OK);
            push(dlpe_pkg::KIND_TX, {8'h0, a[7:0]}, 1'b0, dlpe_pkg::ST_OK);
            if (rd) push(dlpe_pkg::KIND_TX, {8'h0, n}, 1'b0, dlpe_pkg::ST_OK);
            op = c[1:0]; addr = a; cnt = n; left = rd ? 8'd0 : n;
            rxpos = 0; mism = 1'b0; held = 8'd0;
            restart_deframer();
            phase = rd ? 3'd3 : 3'd1;
            return;
        end
        if (c == dlpe_pkg::CMD_PAYLOAD) begin
            if (phase != 3'd1) begin
                reject();
                return;
            end
            if (op == dlpe_pkg::CMD_VAR_WRITE[1:0]) begin
                push(dlpe_pkg::KIND_TX, {8'h0, pay[15:8]}, 1'b0, dlpe_pkg::ST_OK);
                push(dlpe_pkg::KIND_TX, {8'h0, pay[7:0]}, 1'b0, dlpe_pkg::ST_OK);
            end else begin
                push(dlpe_pkg::KIND_TX, {8'h0, pay[7:0]}, 1'b0, dlpe_pkg::ST_OK);
            end
            left = left - 8'd1;
            if (left == 8'd0) begin
                phase = 3'd2; rxpos = 0; mism = 1'b0;
            end
            return;
        end
        if (c != dlpe_pkg::CMD_RX_BYTE) begin
            reject();
            return;
        end
        if (phase == 3'd0) begin
            deframe(rx);
            return;
        end
        if (phase == 3'd1) return;
        if (phase == 3'd2) begin
            if (rx != ack_byte(rxpos)) mism = 1'b1;
            rxpos++;
            if (rxpos >= 6) begin
                push(dlpe_pkg::KIND_STATUS, 16'd0, 1'b0,
                     mism ? dlpe_pkg::ST_MISMATCH : dlpe_pkg::ST_OK);
                finish_txn();
            end
            return;
        end
        total = (op == dlpe_pkg::CMD_VAR_READ[1:0]) ? 7 + 2 * cnt : 7 + cnt;
        fin = (rxpos + 1 >= total);
        if (rxpos < 7) begin
            if (rx != echo_byte(rxpos)) mism = 1'b1;
        end else if (op == dlpe_pkg::CMD_VAR_READ[1:0]) begin
            if (((rxpos - 7) & 1) == 0) held = rx;
            else if (!mism) push(dlpe_pkg::KIND_READ, {held, rx}, fin, dlpe_pkg::ST_OK);
        end else if (!mism) begin
            push(dlpe_pkg::KIND_READ, {8'h0, rx}, fin, dlpe_pkg::ST_OK);
        end
        rxpos = (rxpos + 1) & 9'h1FF;
        if (fin) begin
            push(dlpe_pkg::KIND_STATUS, 16'd0, 1'b0,
                 mism ? dlpe_pkg::ST_MISMATCH : dlpe_pkg::ST_OK);
            finish_txn();
        end
    endfunction

    // compare one output beat with the oldest prediction
    function void check_result(logic [1:0] k, logic [15:0] v, logic l, logic [1:0] s);
        beat_t e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected beat kind=%0d value=%h last=%0d status=%0d",
                     $time, k, v, l, s);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (k !== e.kind || v !== e.value || l !== e.last || s !== e.status) begin
            $display("%0t: mismatch expected kind=%0d value=%h last=%0d status=%0d",
                     $time, e.kind, e.value, e.last, e.status);
            $display("%0t:          actual   kind=%0d value=%h last=%0d status=%0d",
                     $time, k, v, l, s);
            errors++;
        end
    endfunction
endclass

module testbench;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 0, i_rst_n = 0;
    logic        i_cfg_valid = 0;
    logic [1:0]  i_cfg_index = 0;
    logic [7:0]  i_cfg_data = 0;
    logic        i_in_valid = 0;
    logic [2:0]  i_command = 0;
    logic [15:0] i_address = 0, i_payload = 0;
    logic [7:0]  i_count = 0, i_rx_byte = 0;
    logic        i_out_stall = 0;
    logic        o_cfg_ready, o_in_stall, o_out_valid, o_last;
    logic [1:0]  o_kind, o_status;
    logic [15:0] o_value;

    int idle_pct = 0, stall_pct = 0;
    int cycles = 0;
    int sent = 0;
    link_scoreboard sb = new();

    display_link_protocol_engine uut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // check output beats and bound the run; stall is randomized at the falling edge
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL display_link_protocol_engine");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_kind, o_value, o_last, o_status);
    end

    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(99) < stall_pct);

    // send one input beat, with random idle cycles ahead of it
    task automatic send(logic [2:0] c, logic [15:0] a, logic [7:0] n,
                        logic [15:0] pay, logic [7:0] rxb);
        while ($urandom_range(99) < idle_pct) @(negedge i_clk);
        i_in_valid = 1'b1; i_command = c; i_address = a; i_count = n;
        i_payload = pay; i_rx_byte = rxb;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(c, a, n, pay, rxb);
        sent++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic rx(logic [7:0] b);
        send(dlpe_pkg::CMD_RX_BYTE, 16'($urandom), 8'($urandom), 16'($urandom), b);
    endtask

    // hold off until all predicted beats are out, then let the pipe drain
    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [7:0] d);
        i_cfg_valid = 1'b1; i_cfg_index = idx; i_cfg_data = d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_header(idx, d);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // complete transaction with random content; echo mostly correct
    task automatic transaction(bit noisy);
        logic [2:0] c;
        logic [7:0] n, b;
        int unsigned total;
        c = 3'($urandom_range(3));
        n = ($urandom_range(19) == 0) ? dlpe_pkg::count_max(c[1:0])
                                      : 8'($urandom_range(4, 1));
        send(c, 16'($urandom), n, 16'($urandom), 8'($urandom));
        if (c == dlpe_pkg::CMD_REG_WRITE || c == dlpe_pkg::CMD_VAR_WRITE) begin
            for (int i = 0; i < n; i++) begin
                if (noisy && $urandom_range(5) == 0) rx(8'($urandom));
                send(dlpe_pkg::CMD_PAYLOAD, 16'($urandom), 8'($urandom),
                     16'($urandom), 8'($urandom));
            end
            for (int p = 0; p < 6; p++) begin
                b = sb.ack_byte(p);
                if (noisy && $urandom_range(7) == 0) b = 8'($urandom);
                rx(b);
            end
        end else begin
            total = (c == dlpe_pkg::CMD_VAR_READ) ? 7 + 2 * n : 7 + n;
            for (int p = 0; p < total; p++) begin
                b = (p < 7) ? sb.echo_byte(p) : 8'($urandom);
                if (noisy && p < 7 && $urandom_range(15) == 0) b = 8'($urandom);
                rx(b);
            end
        end
    endtask

    task automatic upload_frame();
        int len;
        len = ($urandom_range(15) == 0) ? $urandom_range(255) : $urandom_range(4);
        rx(sb.hdr_hi);
        rx(sb.hdr_lo);
        rx(8'(len));
        for (int i = 0; i < len; i++) rx(8'($urandom));
    endtask

    // run random activity until about the given number of items went in
    task automatic random_phase(int items);
        int start;
        start = sent;
        while (sent - start < items) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: begin
                    transaction($urandom_range(3) == 0);
                end
                5, 6: begin
                    upload_frame();
                end
                default: begin
                    send(3'($urandom_range(7, 4)), 16'($urandom), 8'($urandom),
                         16'($urandom), 8'($urandom));
                end
            endcase
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: extremes, rejects, special cases
        send(dlpe_pkg::CMD_PAYLOAD, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF); // payload when idle
        send(3'd6, 16'd0, 8'd0, 16'd0, 8'd0);
        send(3'd7, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF);
        send(dlpe_pkg::CMD_REG_READ, 16'd0, 8'd0, 16'd0, 8'd0);       // zero count
        send(dlpe_pkg::CMD_VAR_READ, 16'd0, 8'd126, 16'd0, 8'd0);     // count past limit
        send(dlpe_pkg::CMD_REG_WRITE, 16'hFFFF, 8'd1, 16'd0, 8'd0);
        send(dlpe_pkg::CMD_REG_READ, 16'd0, 8'd1, 16'd0, 8'd0);       // start while busy
        rx(8'h00);                                                    // ignored in payload
        send(dlpe_pkg::CMD_PAYLOAD, 16'd0, 8'd0, 16'hFFFF, 8'd0);
        send(dlpe_pkg::CMD_PAYLOAD, 16'd0, 8'd0, 16'd0, 8'd0);        // after payload done
        for (int p = 0; p < 6; p++) rx(sb.ack_byte(p));
        rx(sb.hdr_hi); rx(sb.hdr_lo); rx(8'h00);                      // zero-length upload
        rx(sb.hdr_hi); rx(8'h00);                                     // broken second header
        rx(sb.hdr_hi); rx(sb.hdr_lo); rx(8'd1); rx(8'hFF);
        drain();

        // pass through settings: reset, extremes, random
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 69; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 69; end
                3: begin idle_pct = 15; stall_pct = 15; end
                default: begin idle_pct = $urandom_range(30); stall_pct = 30; end
            endcase
            if (ph == 1) begin
                write_cfg(dlpe_pkg::CFG_HEADER_HIGH, 8'h00);
                write_cfg(dlpe_pkg::CFG_HEADER_LOW, 8'hFF);
            end else if (ph == 3) begin
                write_cfg(dlpe_pkg::CFG_HEADER_HIGH, 8'hFF);
                write_cfg(dlpe_pkg::CFG_HEADER_LOW, 8'h00);
            end else if (ph >= 4) begin
                write_cfg(dlpe_pkg::CFG_HEADER_HIGH, 8'($urandom));
                write_cfg(dlpe_pkg::CFG_HEADER_LOW, 8'($urandom));
            end
            random_phase(45);
            drain();
        end

        stall_pct = 0;
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS display_link_protocol_engine");
        end else begin
            $display("FAIL display_link_protocol_engine");
        end
        $finish;
    end
endmodule

`default_nettype wire
